>>> design/assert_macros.svh
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define UAR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define UAR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is sampled high.
`define UAR_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

>>> design/uar_pkg.sv
// Types, constants and helper functions of the unsigned to ASCII converter.
`default_nettype none

package uar_pkg;

   localparam int VALUE_BITS = 64;
   localparam int STEP_BITS  = 8;
   localparam int CHUNKS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_BITS   = CHUNKS * STEP_BITS;
   localparam int CHUNK_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);
   localparam int ADDR_W     = $clog2(VALUE_BITS);
   localparam int DIGIT_W    = 4;
   localparam int NUMBER_W   = 64;
   localparam int RADIX_W    = 5;
   localparam int CHAR_W     = 8;
   localparam int COUNT_W    = 7;

   typedef logic [PAD_BITS-1:0]  value_type;
   typedef logic [CHUNK_W-1:0]   chunk_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [DIGIT_W-1:0]   digit_type;
   typedef logic [RADIX_W-1:0]   radix_type;
   typedef logic [2:0]           occ_type;
   typedef logic [0:0]           qptr_type;

   typedef struct packed {
      logic [NUMBER_W-1:0] number;
      logic [RADIX_W-1:0]  radix;
      logic                upper_case;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  char_code;
      logic [COUNT_W-1:0] digit_count;
      logic               last_digit;
   } rsp_type;

   typedef struct packed {
      value_type value;
      radix_type base;
      logic      upper;
   } job_type;

   typedef struct packed {
      logic [STEP_BITS-1:0] q;
      digit_type            rem;
   } step_type;

   typedef struct packed {
      occ_type level;
      logic    pop;
   } rspq_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_EMIT
   } back_state_type;

   localparam radix_type RADIX_MIN     = 5'd2;
   localparam radix_type RADIX_MAX     = 5'd16;
   localparam digit_type DIGIT_TEN     = 4'd10;
   localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
   localparam occ_type   QDEPTH        = 3'd2;
   localparam chunk_type CHUNK_LAST    = chunk_type'(CHUNKS - 1);

   function automatic radix_type clamp_radix(input radix_type r);
      radix_type b;
      if (r < RADIX_MIN) begin
         b = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         b = RADIX_MAX;
      end else begin
         b = r;
      end
      return b;
   endfunction

   function automatic value_type to_value(input logic [NUMBER_W-1:0] n);
      return value_type'(n[VALUE_BITS-1:0]);
   endfunction

   // Long division of one chunk of the dividend by a small base, MSB first.
   function automatic step_type div_chunk(input digit_type rem,
                                          input logic [STEP_BITS-1:0] bits,
                                          input radix_type base);
      logic [RADIX_W-1:0] t;
      digit_type          r;
      step_type           s;
      r   = rem;
      s.q = '0;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         t = {r, bits[i]};
         if (t >= base) begin
            s.q[i] = 1'b1;
            t      = t - base;
         end
         r = t[DIGIT_W-1:0];
      end
      s.rem = r;
      return s;
   endfunction

   function automatic value_type shift_in(input value_type v,
                                          input logic [STEP_BITS-1:0] q);
      return (v << STEP_BITS) | value_type'(q);
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input digit_type d, input logic upper);
      logic [CHAR_W-1:0] c;
      if (d < DIGIT_TEN) begin
         c = ASCII_ZERO + CHAR_W'(d);
      end else if (upper) begin
         c = ASCII_UPPER_A + CHAR_W'(d - DIGIT_TEN);
      end else begin
         c = ASCII_LOWER_A + CHAR_W'(d - DIGIT_TEN);
      end
      return c;
   endfunction

   function automatic logic [COUNT_W-1:0] to_count(input cnt_type c);
      return COUNT_W'(c);
   endfunction

endpackage

`default_nettype wire

>>> design/uar_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module uar_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

>>> design/uar_front.sv
// Input side: clamps the base, masks the value and queues jobs for the converter.
`default_nettype none

module uar_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire uar_pkg::req_type  req_data,
   output logic                   full,
   output logic                   job_vld,
   output uar_pkg::job_type       job_data,
   input  wire logic              job_pop
);

   uar_pkg::job_type  slot_ff [2];
   uar_pkg::job_type  job_new;
   uar_pkg::qptr_type wr_ptr_ff, wr_ptr_in;
   uar_pkg::qptr_type rd_ptr_ff, rd_ptr_in;
   uar_pkg::occ_type  level_ff, level_in;
   logic              accept;
   logic              take;

   assign full     = (level_ff == uar_pkg::QDEPTH);
   assign job_vld  = (level_ff != uar_pkg::occ_type'(0));
   assign job_data = slot_ff[rd_ptr_ff];
   assign accept   = push & ~full;
   assign take     = job_pop & job_vld;

   always_comb begin
      job_new.value = uar_pkg::to_value(req_data.number);
      job_new.base  = uar_pkg::clamp_radix(req_data.radix);
      job_new.upper = req_data.upper_case;
   end

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + uar_pkg::qptr_type'(1) : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + uar_pkg::qptr_type'(1) : rd_ptr_ff;
      level_in  = level_ff + uar_pkg::occ_type'(accept) - uar_pkg::occ_type'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= job_new;
      end
   end

endmodule

`default_nettype wire

>>> design/uar_rspq.sv
// Two-entry result queue that drives the result ports.
`default_nettype none

module uar_rspq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              beat_push,
   input  wire uar_pkg::rsp_type  beat_data,
   output logic                   empty,
   output uar_pkg::rsp_type       rsp_data,
   input  wire logic              pop,
   output uar_pkg::rspq_stat_type stat
);

   uar_pkg::rsp_type  slot_ff [2];
   uar_pkg::qptr_type wr_ptr_ff, wr_ptr_in;
   uar_pkg::qptr_type rd_ptr_ff, rd_ptr_in;
   uar_pkg::occ_type  level_ff, level_in;
   logic              take;

   assign empty      = (level_ff == uar_pkg::occ_type'(0));
   assign rsp_data   = slot_ff[rd_ptr_ff];
   assign take       = pop & ~empty;
   assign stat.level = level_ff;
   assign stat.pop   = take;

   always_comb begin
      wr_ptr_in = beat_push ? wr_ptr_ff + uar_pkg::qptr_type'(1) : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + uar_pkg::qptr_type'(1) : rd_ptr_ff;
      level_in  = level_ff + uar_pkg::occ_type'(beat_push) - uar_pkg::occ_type'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_push) begin
         slot_ff[wr_ptr_ff] <= beat_data;
      end
   end

endmodule

`default_nettype wire

>>> design/uar_back.sv
// Converter: repeated chunked division into a digit store, then reversed readout.
`default_nettype none

module uar_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   job_vld,
   input  wire uar_pkg::job_type       job_data,
   output logic                        job_pop,
   input  wire uar_pkg::rspq_stat_type stat,
   output logic                        beat_push,
   output uar_pkg::rsp_type            beat_data
);

   uar_pkg::back_state_type state_ff, state_in;
   uar_pkg::value_type      val_ff, val_in;
   uar_pkg::radix_type      base_ff, base_in;
   logic                    upper_ff, upper_in;
   uar_pkg::digit_type      rem_ff, rem_in;
   logic                    nz_ff, nz_in;
   uar_pkg::chunk_type      chunk_ff, chunk_in;
   uar_pkg::cnt_type        count_ff, count_in;
   uar_pkg::cnt_type        left_ff, left_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic                    rd_last_ff, rd_last_in;
   logic                    rd_upper_ff, rd_upper_in;
   uar_pkg::cnt_type        rd_count_ff, rd_count_in;

   uar_pkg::step_type       step;
   logic                    pass_end;
   logic                    more;
   logic                    issue;
   uar_pkg::occ_type        occ_next;
   logic                    ram_we;
   uar_pkg::addr_type       ram_waddr;
   logic                    ram_re;
   uar_pkg::addr_type       ram_raddr;
   uar_pkg::digit_type      ram_rdata;

   assign step     = uar_pkg::div_chunk(rem_ff, val_ff[uar_pkg::PAD_BITS-1 -: uar_pkg::STEP_BITS],
                                        base_ff);
   assign pass_end = (chunk_ff == uar_pkg::CHUNK_LAST);
   assign more     = nz_ff | (|step.q);

   // A read issued now lands in the queue next cycle, so leave room for it
   // after counting the beat already in flight and any pop this cycle.
   assign occ_next = stat.level + uar_pkg::occ_type'(rd_vld_ff) - uar_pkg::occ_type'(stat.pop);
   assign issue    = (state_ff == uar_pkg::BK_EMIT) && (occ_next < uar_pkg::QDEPTH);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         uar_pkg::BK_IDLE: begin
            if (job_vld) begin
               state_in = uar_pkg::BK_DIV;
            end
         end
         uar_pkg::BK_DIV: begin
            if (pass_end && !more) begin
               state_in = uar_pkg::BK_EMIT;
            end
         end
         uar_pkg::BK_EMIT: begin
            if (issue && left_ff == uar_pkg::cnt_type'(1)) begin
               state_in = uar_pkg::BK_IDLE;
            end
         end
         default: state_in = uar_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      val_in      = val_ff;
      base_in     = base_ff;
      upper_in    = upper_ff;
      rem_in      = rem_ff;
      nz_in       = nz_ff;
      chunk_in    = chunk_ff;
      count_in    = count_ff;
      left_in     = left_ff;
      rd_vld_in   = 1'b0;
      rd_last_in  = rd_last_ff;
      rd_upper_in = rd_upper_ff;
      rd_count_in = rd_count_ff;
      job_pop     = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = count_ff[uar_pkg::ADDR_W-1:0];
      ram_re      = 1'b0;
      ram_raddr   = uar_pkg::addr_type'(uar_pkg::cnt_type'(left_ff - 1'b1));
      unique case (state_ff)
         uar_pkg::BK_IDLE: begin
            if (job_vld) begin
               job_pop  = 1'b1;
               val_in   = job_data.value;
               base_in  = job_data.base;
               upper_in = job_data.upper;
               rem_in   = '0;
               nz_in    = 1'b0;
               chunk_in = '0;
               count_in = '0;
            end
         end
         uar_pkg::BK_DIV: begin
            val_in   = uar_pkg::shift_in(val_ff, step.q);
            rem_in   = step.rem;
            nz_in    = more;
            chunk_in = chunk_ff + uar_pkg::chunk_type'(1);
            if (pass_end) begin
               // The final remainder of a pass is the next digit, least significant first.
               ram_we   = 1'b1;
               count_in = count_ff + uar_pkg::cnt_type'(1);
               left_in  = count_ff + uar_pkg::cnt_type'(1);
               rem_in   = '0;
               nz_in    = 1'b0;
               chunk_in = '0;
            end
         end
         uar_pkg::BK_EMIT: begin
            if (issue) begin
               ram_re      = 1'b1;
               left_in     = left_ff - uar_pkg::cnt_type'(1);
               rd_vld_in   = 1'b1;
               rd_last_in  = (left_ff == uar_pkg::cnt_type'(1));
               rd_upper_in = upper_ff;
               rd_count_in = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= uar_pkg::BK_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      base_ff     <= base_in;
      upper_ff    <= upper_in;
      rem_ff      <= rem_in;
      nz_ff       <= nz_in;
      chunk_ff    <= chunk_in;
      count_ff    <= count_in;
      left_ff     <= left_in;
      rd_last_ff  <= rd_last_in;
      rd_upper_ff <= rd_upper_in;
      rd_count_ff <= rd_count_in;
   end

   uar_ram #(
      .WIDTH (uar_pkg::DIGIT_W),
      .DEPTH (uar_pkg::VALUE_BITS)
   ) u_digits (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (step.rem),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign beat_push             = rd_vld_ff;
   assign beat_data.char_code   = uar_pkg::digit_char(ram_rdata, rd_upper_ff);
   assign beat_data.digit_count = uar_pkg::to_count(rd_count_ff);
   assign beat_data.last_digit  = rd_last_ff;

endmodule

`default_nettype wire

>>> design/unsigned_to_ascii_radix.sv
// Converts an unsigned value to ASCII digits in base 2 to 16, one digit per beat,
// most significant digit first; every beat carries the digit count and the final
// one is marked. Bases below 2 act as 2, above 16 as 16. The divide unit produces
// one digit per pass over the dividend (one 8-bit chunk of the 64-bit dividend per
// cycle), the digits are written to a small digit store, and they are then read
// back in reverse at one beat per cycle while the result side keeps popping. Up to
// two items wait in the input queue while one is converted, and results wait in a
// two-entry queue.
`default_nettype none

module unsigned_to_ascii_radix (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire uar_pkg::req_type req_data,
   output logic                  full,
   output logic                  empty,
   output uar_pkg::rsp_type      rsp_data,
   input  wire logic             pop
);

   logic                   job_vld;
   uar_pkg::job_type       job_data;
   logic                   job_pop;
   uar_pkg::rspq_stat_type stat;
   logic                   beat_push;
   uar_pkg::rsp_type       beat_data;

   uar_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .job_vld  (job_vld),
      .job_data (job_data),
      .job_pop  (job_pop)
   );

   uar_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_vld   (job_vld),
      .job_data  (job_data),
      .job_pop   (job_pop),
      .stat      (stat),
      .beat_push (beat_push),
      .beat_data (beat_data)
   );

   uar_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .beat_push (beat_push),
      .beat_data (beat_data),
      .empty     (empty),
      .rsp_data  (rsp_data),
      .pop       (pop),
      .stat      (stat)
   );

endmodule

`default_nettype wire

>>> design/uar_checker.sv
// Port-level checker for the converter, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module uar_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             full,
   input wire logic             empty,
   input wire uar_pkg::rsp_type rsp_data,
   input wire logic             pop
);

   logic                         beat_wait;
   logic                         one_digit;
   logic                         is_digit;
   logic                         mid_pop;
   logic [uar_pkg::COUNT_W-1:0]  count_now;

   assign beat_wait = !empty && !pop;
   assign one_digit = !empty && rsp_data.digit_count == 7'd1;
   assign is_digit  = (rsp_data.char_code >= 8'h30 && rsp_data.char_code <= 8'h39) ||
                      (rsp_data.char_code >= 8'h41 && rsp_data.char_code <= 8'h46) ||
                      (rsp_data.char_code >= 8'h61 && rsp_data.char_code <= 8'h66);
   assign mid_pop   = !empty && pop && !rsp_data.last_digit;
   assign count_now = rsp_data.digit_count;

   `UAR_ASSERT_RESET(a_reset_clear, empty && !full, "queues not clear after reset")

   `UAR_ASSERT_NEXT(a_stall_hold, beat_wait, !empty && $stable(rsp_data), "stalled beat changed")

   `UAR_ASSERT_NOW(a_single_last, one_digit, rsp_data.last_digit, "one-digit run not last")

   `UAR_ASSERT_NOW(a_char_digit, !empty, is_digit, "beat is not a digit character")

   `UAR_ASSERT_NOW(a_count_steady, mid_pop ##1 !empty, $stable(count_now), "count changed")

endmodule

bind unsigned_to_ascii_radix uar_checker u_checker (.*);

`default_nettype wire
